/* design/lwh_pkg.sv */
// shared types, constants and codes of the local window label histogram
`default_nettype none

package lwh_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_MAX_RADIUS = 7;

  // number of bins and label width are fixed by the word fields
  localparam int MAX_LABELS = 16;
  localparam int LBL_W      = 4;
  localparam int BIN_W      = 4;
  localparam int XY_W       = 6;
  localparam int CH_W       = 2;
  localparam int CNT_OUT_W  = 8;
  localparam int FRAC_W     = 17;
  localparam int STAT_W     = 2;
  localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);

  // configuration register widths
  localparam int NL_W       = 5;
  localparam int RAD_W      = 3;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LABELS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  // configuration reset values
  localparam logic [NL_W-1:0]  RST_NUM_LABELS   = 5'd16;
  localparam logic [RAD_W-1:0] RST_RADIUS       = 3'd1;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 7'd64;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_LABEL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_COORD = 2'd2;

  // input word
  typedef struct packed {
    logic             op;
    logic [XY_W-1:0]  pos_x;
    logic [XY_W-1:0]  pos_y;
    logic [CH_W-1:0]  channel;
    logic [LBL_W-1:0] label_in;
  } lwh_in_t;

  // result word
  typedef struct packed {
    logic [BIN_W-1:0]     bin;
    logic [CNT_OUT_W-1:0] bin_count;
    logic [FRAC_W-1:0]    fraction;
    logic [STAT_W-1:0]    status;
    logic                 last;
  } lwh_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic              load_in;
    logic              mem_we;
    logic              scan_init;
    logic              scan_step;
    logic              div_start;
    logic              load_ack;
    logic [STAT_W-1:0] ack_status;
    logic              load_bin;
    logic              bin_inc;
  } lwh_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic coord_bad;
    logic label_bad;
    logic is_query;
    logic scan_last;
    logic div_busy;
    logic bin_last;
  } lwh_sts_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACK,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } lwh_state_e;

endpackage

`default_nettype wire

/* design/lwh_ctrl.sv */
// controller state machine of the local window label histogram
`default_nettype none

module lwh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire lwh_pkg::lwh_sts_t sts_i,
  output lwh_pkg::lwh_cmd_t      cmd_o
);

  lwh_pkg::lwh_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lwh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lwh_pkg::ST_CHECK;
      end
      lwh_pkg::ST_CHECK: begin
        if (sts_i.coord_bad || !sts_i.is_query) begin
          state_d = lwh_pkg::ST_ACK;
        end else begin
          state_d = lwh_pkg::ST_SCAN;
        end
      end
      lwh_pkg::ST_ACK: begin
        if (!out_stall_i) state_d = lwh_pkg::ST_IDLE;
      end
      lwh_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = lwh_pkg::ST_DRAIN;
      end
      lwh_pkg::ST_DRAIN: begin
        state_d = lwh_pkg::ST_DIV_LOAD;
      end
      lwh_pkg::ST_DIV_LOAD: begin
        state_d = lwh_pkg::ST_DIV;
      end
      lwh_pkg::ST_DIV: begin
        if (!sts_i.div_busy) state_d = lwh_pkg::ST_OUT;
      end
      lwh_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = sts_i.bin_last ? lwh_pkg::ST_IDLE : lwh_pkg::ST_DIV_LOAD;
        end
      end
      default: state_d = lwh_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      lwh_pkg::ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_in  = in_valid_i;
      end
      lwh_pkg::ST_CHECK: begin
        if (sts_i.coord_bad) begin
          cmd_o.load_ack   = 1'b1;
          cmd_o.ack_status = lwh_pkg::STATUS_COORD;
        end else if (!sts_i.is_query) begin
          cmd_o.load_ack = 1'b1;
          if (sts_i.label_bad) begin
            cmd_o.ack_status = lwh_pkg::STATUS_LABEL;
          end else begin
            cmd_o.ack_status = lwh_pkg::STATUS_OK;
            cmd_o.mem_we     = 1'b1;
          end
        end else begin
          cmd_o.scan_init = 1'b1;
        end
      end
      lwh_pkg::ST_ACK: begin
        out_valid_o = 1'b1;
      end
      lwh_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      lwh_pkg::ST_DRAIN: begin
        cmd_o = '0;
      end
      lwh_pkg::ST_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
      end
      lwh_pkg::ST_DIV: begin
        cmd_o.load_bin = !sts_i.div_busy;
      end
      lwh_pkg::ST_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.bin_inc = !out_stall_i && !sts_i.bin_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/lwh_datapath.sv */
// datapath: configuration, label memory, window scan, bin counters, divider, result register
`default_nettype none

module lwh_datapath #(
  parameter int MAX_WIDTH  = lwh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lwh_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = lwh_pkg::DEF_CHANNELS,
  parameter int MAX_RADIUS = lwh_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lwh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lwh_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire lwh_pkg::lwh_in_t                  in_word_i,
  input  wire lwh_pkg::lwh_cmd_t                 cmd_i,
  output lwh_pkg::lwh_sts_t                      sts_o,
  output lwh_pkg::lwh_out_t                      out_word_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int CNT_W = $clog2(WIN * WIN + 1);

  // configuration registers
  logic [lwh_pkg::NL_W-1:0]  num_labels_q;
  logic [lwh_pkg::RAD_W-1:0] radius_q;
  logic [lwh_pkg::DIM_W-1:0] width_q;
  logic [lwh_pkg::DIM_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_labels_q <= lwh_pkg::RST_NUM_LABELS;
      radius_q     <= lwh_pkg::RST_RADIUS;
      width_q      <= lwh_pkg::RST_IMAGE_WIDTH;
      height_q     <= lwh_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lwh_pkg::CFG_NUM_LABELS:   num_labels_q <= cfg_wdata_i[lwh_pkg::NL_W-1:0];
        lwh_pkg::CFG_RADIUS:       radius_q     <= cfg_wdata_i[lwh_pkg::RAD_W-1:0];
        lwh_pkg::CFG_IMAGE_WIDTH:  width_q      <= cfg_wdata_i[lwh_pkg::DIM_W-1:0];
        lwh_pkg::CFG_IMAGE_HEIGHT: height_q     <= cfg_wdata_i[lwh_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective register values after clamping
  logic [lwh_pkg::NL_W-1:0]  nl_eff;
  logic [lwh_pkg::RAD_W-1:0] r_eff;
  logic [lwh_pkg::DIM_W-1:0] w_eff;
  logic [lwh_pkg::DIM_W-1:0] h_eff;

  always_comb begin
    nl_eff = num_labels_q;
    if (num_labels_q == '0) nl_eff = lwh_pkg::NL_W'(1);
    if (int'(num_labels_q) > lwh_pkg::MAX_LABELS) nl_eff = lwh_pkg::NL_W'(lwh_pkg::MAX_LABELS);
    r_eff = (int'(radius_q) > MAX_RADIUS) ? lwh_pkg::RAD_W'(MAX_RADIUS) : radius_q;
    w_eff = (int'(width_q) > MAX_WIDTH) ? lwh_pkg::DIM_W'(MAX_WIDTH) : width_q;
    h_eff = (int'(height_q) > MAX_HEIGHT) ? lwh_pkg::DIM_W'(MAX_HEIGHT) : height_q;
  end

  // accepted input word
  lwh_pkg::lwh_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_word_i;
  end

  // item checks
  assign sts_o.coord_bad = ({1'b0, in_q.pos_x} >= w_eff) || ({1'b0, in_q.pos_y} >= h_eff)
                           || (int'(in_q.channel) >= CHANNELS);
  assign sts_o.label_bad = ({1'b0, in_q.label_in} >= nl_eff);
  assign sts_o.is_query  = (in_q.op == lwh_pkg::OP_QUERY);

  // window bounds, clipped at the borders (upper bounds exclusive)
  logic [lwh_pkg::XY_W-1:0]  x0, y0;
  logic [lwh_pkg::DIM_W-1:0] x1, y1, x_end, y_end;

  always_comb begin
    x0    = (in_q.pos_x > lwh_pkg::XY_W'(r_eff)) ? in_q.pos_x - lwh_pkg::XY_W'(r_eff) : '0;
    y0    = (in_q.pos_y > lwh_pkg::XY_W'(r_eff)) ? in_q.pos_y - lwh_pkg::XY_W'(r_eff) : '0;
    x_end = {1'b0, in_q.pos_x} + lwh_pkg::DIM_W'(r_eff) + lwh_pkg::DIM_W'(1);
    y_end = {1'b0, in_q.pos_y} + lwh_pkg::DIM_W'(r_eff) + lwh_pkg::DIM_W'(1);
    x1    = (x_end > w_eff) ? w_eff : x_end;
    y1    = (y_end > h_eff) ? h_eff : y_end;
  end

  // window scan counters
  logic [lwh_pkg::XY_W-1:0] cx_q, cy_q;
  logic                     cy_wrap;
  logic                     cx_done;

  assign cy_wrap         = ({1'b0, cy_q} + lwh_pkg::DIM_W'(1)) == y1;
  assign cx_done         = ({1'b0, cx_q} + lwh_pkg::DIM_W'(1)) == x1;
  assign sts_o.scan_last = cy_wrap && cx_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      cx_q <= x0;
      cy_q <= y0;
    end else if (cmd_i.scan_step) begin
      if (cy_wrap) begin
        cy_q <= y0;
        cx_q <= cx_q + lwh_pkg::XY_W'(1);
      end else begin
        cy_q <= cy_q + lwh_pkg::XY_W'(1);
      end
    end
  end

  // label memory addresses
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = AW'((AW'(in_q.pos_y) * AW'(MAX_WIDTH) + AW'(in_q.pos_x)) * AW'(CHANNELS)
                       + AW'(in_q.channel));
  assign rd_addr = AW'((AW'(cy_q) * AW'(MAX_WIDTH) + AW'(cx_q)) * AW'(CHANNELS)
                       + AW'(in_q.channel));

  // label memory, registered read
  logic [lwh_pkg::LBL_W-1:0] label_mem_q [DEPTH];
  logic [lwh_pkg::LBL_W-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) label_mem_q[wr_addr] <= in_q.label_in;
    mem_rd_q <= label_mem_q[rd_addr];
  end

  // read data pending flag
  logic rd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_step;
    end
  end

  // bin counters and window total; stale labels are skipped
  logic [CNT_W-1:0] bin_cnt_q [lwh_pkg::MAX_LABELS];
  logic [CNT_W-1:0] total_q;
  logic             cnt_en;

  assign cnt_en = rd_pend_q && ({1'b0, mem_rd_q} < nl_eff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      total_q <= '0;
      for (int i = 0; i < lwh_pkg::MAX_LABELS; i++) begin
        bin_cnt_q[i] <= '0;
      end
    end else if (cnt_en) begin
      total_q <= total_q + CNT_W'(1);
      for (int i = 0; i < lwh_pkg::MAX_LABELS; i++) begin
        if (mem_rd_q == lwh_pkg::LBL_W'(i)) bin_cnt_q[i] <= bin_cnt_q[i] + CNT_W'(1);
      end
    end
  end

  // current bin
  logic [lwh_pkg::BIN_W-1:0] bin_q;
  logic [CNT_W-1:0]          cur_cnt;

  assign cur_cnt        = bin_cnt_q[bin_q];
  assign sts_o.bin_last = ({1'b0, bin_q} + lwh_pkg::NL_W'(1)) == nl_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      bin_q <= '0;
    end else if (cmd_i.bin_inc) begin
      bin_q <= bin_q + lwh_pkg::BIN_W'(1);
    end
  end

  // restoring divider, one quotient bit a cycle: count * 65536 / total
  logic [CNT_W:0]              div_rem_q;
  logic [lwh_pkg::FRAC_W-1:0]  div_quo_q;
  logic [lwh_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic                        div_ge;
  logic [CNT_W:0]              div_diff;

  assign div_ge         = div_rem_q >= {1'b0, total_q};
  assign div_diff       = div_ge ? div_rem_q - {1'b0, total_q} : div_rem_q;
  assign sts_o.div_busy = (div_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= lwh_pkg::DIV_CNT_W'(lwh_pkg::FRAC_W);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - lwh_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_rem_q <= {1'b0, cur_cnt};
      div_quo_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= {div_diff[CNT_W-1:0], 1'b0};
      div_quo_q <= {div_quo_q[lwh_pkg::FRAC_W-2:0], div_ge};
    end
  end

  // result register
  lwh_pkg::lwh_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ack) begin
      out_q.bin       <= '0;
      out_q.bin_count <= '0;
      out_q.fraction  <= '0;
      out_q.status    <= cmd_i.ack_status;
      out_q.last      <= 1'b1;
    end else if (cmd_i.load_bin) begin
      out_q.bin       <= bin_q;
      out_q.bin_count <= lwh_pkg::CNT_OUT_W'(cur_cnt);
      out_q.fraction  <= (total_q == '0) ? '0 : div_quo_q;
      out_q.status    <= lwh_pkg::STATUS_OK;
      out_q.last      <= sts_o.bin_last;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

/* design/local_window_label_histogram_core.sv */
// top level of the local window label histogram
`default_nettype none

// Stores a label image of MAX_WIDTH x MAX_HEIGHT pixels and CHANNELS channels in one
// memory with a write port and a registered read port, and answers one word at a time.
// A write word is checked and, if good, stored; its acknowledgement is held until taken.
// A query word scans the clipped window of N pixels (at most 225 at radius 7), one
// memory read per cycle, then the bit-serial divider forms the 17-bit fraction of each
// bin in turn, and each bin's result is held until taken. Input is stalled whenever
// the block is busy with a word. The memory has no reset: a pixel must be written
// before a query window covers it. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i; the user must do so only while idle, as the block does not enforce it.
module local_window_label_histogram_core #(
  parameter int MAX_WIDTH  = lwh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lwh_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = lwh_pkg::DEF_CHANNELS,
  parameter int MAX_RADIUS = lwh_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lwh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lwh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire lwh_pkg::lwh_in_t               in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output lwh_pkg::lwh_out_t                   out_word_o
);

  lwh_pkg::lwh_cmd_t cmd;
  lwh_pkg::lwh_sts_t sts;

  // controller
  lwh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  lwh_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

  // no new word is taken while a result is offered
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // the block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted word");

  // the memory is written only by a valid in-range write word
  a_store_only_good_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_we |-> (!sts.coord_bad && !sts.label_bad && !sts.is_query))
    else $error("memory written by a rejected or query word");

  // an error result is always the only result of its word
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != lwh_pkg::STATUS_OK)) |-> out_word_o.last)
    else $error("error result not marked last");

endmodule

`default_nettype wire
